// ----- rtl/frx_pkg.sv -----
// Shared types and constants of the framed payload receiver.
package frx_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_LEN = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_TIMEOUT  = 2'd3
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_DONE    = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    REG_CLASS   = 2'd0,
    REG_MESSAGE = 2'd1,
    REG_LIMIT   = 2'd2,
    REG_TIMEOUT = 2'd3
  } reg_idx_t;

  localparam logic [7:0]  SYNC_FIRST     = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND    = 8'h62;
  localparam logic [15:0] LIMIT_RESET    = 16'd128;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd5000;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_value;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_value;
    logic [15:0] payload_index;
    logic [1:0]  status;
    logic [15:0] frame_length;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  class_code;
    logic [7:0]  message_code;
    logic [15:0] buffer_limit;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

// ----- rtl/frx_cfg_regs.sv -----
// Configuration registers of the framed payload receiver.
module frx_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_wdata,
  output frx_pkg::cfg_t cfg
);
  import frx_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.class_code    <= '0;
      cfg_r.message_code  <= '0;
      cfg_r.buffer_limit  <= LIMIT_RESET;
      cfg_r.timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CLASS:   cfg_r.class_code    <= cfg_wdata[7:0];
        REG_MESSAGE: cfg_r.message_code  <= cfg_wdata[7:0];
        REG_LIMIT:   cfg_r.buffer_limit  <= cfg_wdata;
        REG_TIMEOUT: cfg_r.timeout_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/frx_in_stage.sv -----
// Input register stage of the framed payload receiver.
module frx_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  frx_pkg::in_item_t in_item,
  input  logic              adv,
  output logic              fire,
  output frx_pkg::in_item_t item
);
  import frx_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_ready = !valid_r || adv;
  assign fire     = valid_r && adv;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (adv) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- rtl/frx_core.sv -----
// Frame hunt, length capture and payload sequencing of the receiver.
module frx_core (
  input  logic               clk,
  input  logic               rst_n,
  input  frx_pkg::cfg_t      cfg,
  input  logic               fire,
  input  frx_pkg::in_item_t  item,
  output logic               res_valid,
  output frx_pkg::out_item_t res
);
  import frx_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SYNC_A, PH_SYNC_B, PH_CLASS, PH_MSG,
    PH_LEN_LO, PH_LEN_HI, PH_DATA, PH_CK_A, PH_CK_B
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] exp_len_r, exp_len_nxt;
  logic [15:0] rcv_cnt_r, rcv_cnt_nxt;
  logic [15:0] ticks_r, ticks_nxt;

  logic [15:0] tick_inc;
  logic [15:0] cnt_inc;
  logic [15:0] len_full;
  logic [7:0]  b;

  assign tick_inc = ticks_r + 16'd1;
  assign cnt_inc  = rcv_cnt_r + 16'd1;
  assign b        = item.rx_value;
  assign len_full = {b, exp_len_r[7:0]};

  always_comb begin
    phase_nxt   = phase_r;
    exp_len_nxt = exp_len_r;
    rcv_cnt_nxt = rcv_cnt_r;
    ticks_nxt   = ticks_r;
    res_valid   = 1'b0;
    res         = '0;
    if (fire) begin
      priority if (op_t'(item.operation) == OP_START) begin
        phase_nxt   = PH_SYNC_A;
        exp_len_nxt = '0;
        rcv_cnt_nxt = '0;
        ticks_nxt   = '0;
      end else if (phase_r == PH_IDLE || op_t'(item.operation) == OP_NONE) begin
      end else if (op_t'(item.operation) == OP_TICK) begin
        ticks_nxt = tick_inc;
        if (tick_inc >= cfg.timeout_ticks || tick_inc == 16'd0) begin
          res_valid        = 1'b1;
          res.result_kind  = KIND_DONE;
          res.status       = ST_TIMEOUT;
          phase_nxt        = PH_IDLE;
        end
      end else begin
        unique case (phase_r)
          PH_SYNC_A: begin
            if (b == SYNC_FIRST) phase_nxt = PH_SYNC_B;
          end
          PH_SYNC_B: phase_nxt = (b == SYNC_SECOND) ? PH_CLASS : PH_SYNC_A;
          PH_CLASS:  phase_nxt = (b == cfg.class_code) ? PH_MSG : PH_SYNC_A;
          PH_MSG: begin
            if (b == cfg.message_code) begin
              phase_nxt   = PH_LEN_LO;
              exp_len_nxt = '0;
            end else begin
              phase_nxt = PH_SYNC_A;
            end
          end
          PH_LEN_LO: begin
            exp_len_nxt = {8'd0, b};
            phase_nxt   = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            exp_len_nxt = len_full;
            if (len_full == 16'd0) begin
              res_valid       = 1'b1;
              res.result_kind = KIND_DONE;
              res.status      = ST_ZERO_LEN;
              phase_nxt       = PH_IDLE;
            end else begin
              rcv_cnt_nxt = '0;
              phase_nxt   = PH_DATA;
            end
          end
          PH_DATA: begin
            res_valid = 1'b1;
            if (rcv_cnt_r >= cfg.buffer_limit) begin
              res.result_kind = KIND_DONE;
              res.status      = ST_OVERFLOW;
              phase_nxt       = PH_IDLE;
            end else begin
              rcv_cnt_nxt       = cnt_inc;
              res.result_kind   = KIND_PAYLOAD;
              res.payload_value = b;
              res.payload_index = rcv_cnt_r;
              if (cnt_inc == exp_len_r) phase_nxt = PH_CK_A;
            end
          end
          PH_CK_A: phase_nxt = PH_CK_B;
          PH_CK_B: begin
            res_valid        = 1'b1;
            res.result_kind  = KIND_DONE;
            res.status       = ST_OK;
            res.frame_length = exp_len_r;
            phase_nxt        = PH_IDLE;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      exp_len_r <= '0;
      rcv_cnt_r <= '0;
      ticks_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      exp_len_r <= exp_len_nxt;
      rcv_cnt_r <= rcv_cnt_nxt;
      ticks_r   <= ticks_nxt;
    end
  end

  a_start_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op_t'(item.operation) == OP_START
    |=> phase_r == PH_SYNC_A && rcv_cnt_r == 16'd0 && ticks_r == 16'd0)
    else $error("start did not rearm the receiver");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.result_kind == KIND_DONE |=> phase_r == PH_IDLE)
    else $error("finished result without return to idle");

  a_index_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.result_kind == KIND_PAYLOAD
    |-> res.payload_index < cfg.buffer_limit)
    else $error("payload index beyond buffer limit");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> exp_len_r != 16'd0 && rcv_cnt_r < exp_len_r)
    else $error("payload count out of step with length");

endmodule

// ----- rtl/frx_out_stage.sv -----
// Result register stage of the framed payload receiver.
module frx_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  frx_pkg::out_item_t res,
  output logic               adv,
  output logic               out_valid,
  input  logic               out_ready,
  output frx_pkg::out_item_t out_item
);
  import frx_pkg::*;

  logic      valid_r;
  out_item_t item_r;

  assign adv       = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      item_r <= res;
    end
  end

endmodule

// ----- rtl/framed_payload_receiver_unit.sv -----
// Framed payload receiver: top level.
// A result passes the input register and the core, then is offered from the result register.
// Throughput: one transaction per cycle, set by the input and result registers.
// A held result stalls the input only while out_ready stays low.
// Synchronous active-low reset: idle, not armed, registers at reset values.
module framed_payload_receiver_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  frx_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output frx_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import frx_pkg::*;

  cfg_t      cfg;
  logic      adv;
  logic      fire;
  in_item_t  item;
  logic      res_valid;
  out_item_t res;

  frx_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  frx_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .adv      (adv),
    .fire     (fire),
    .item     (item)
  );

  frx_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  frx_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
